// ===== src/bgd_pkg.sv =====
// Shared types and constants for the button gesture detector.
`timescale 1ns / 1ps

package bgd_pkg;

	localparam int STAMP_W     = 32;
	localparam int TICKS_W     = 16;
	localparam int TALLY_W     = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int NUM_BUTTONS_DEF = 3;

	localparam logic [TALLY_W-1:0] CLICKS_FOR_DOUBLE = TALLY_W'(2);

	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = CFG_IDX_W'(1);

	localparam logic [TICKS_W-1:0] LONG_PRESS_RST   = TICKS_W'(1000);
	localparam logic [TICKS_W-1:0] DOUBLE_CLICK_RST = TICKS_W'(300);

	typedef struct packed {
		logic press;
		logic long_press;
		logic double_click;
		logic held;
	} btn_flags_t;

endpackage

// ===== src/button_gesture_detector_core.sv =====
// Top level of the button gesture detector: input register, button lanes, result register.
`timescale 1ns / 1ps

// Takes one sampling tick per input transaction and returns one result transaction per tick
// with press, long-press, double-click and held masks, one bit per button. One tick is
// accepted every cycle unless both registers hold a tick and m_axis_tready is low; a tick
// is captured in the input register and moves into the result register once that is empty or being read. The
// output register lets a new tick be accepted while a result still waits. The user must write thresholds
// through the cfg port only while the block is idle; the block itself does not enforce it.
module button_gesture_detector_core #(
	parameter int NUM_BUTTONS = bgd_pkg::NUM_BUTTONS_DEF,
	parameter int IN_TW  = ((bgd_pkg::STAMP_W + NUM_BUTTONS + 7) / 8) * 8,
	parameter int OUT_TW = ((4 * NUM_BUTTONS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bgd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bgd_pkg::TICKS_W-1:0]   cfg_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// now_ticks [31:0], button_levels [32 +: NUM_BUTTONS]
	input  logic [IN_TW-1:0]              s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// press_mask, long_press_mask, double_click_mask, held_mask; NUM_BUTTONS bits each
	output logic [OUT_TW-1:0]             m_axis_tdata
);
	import bgd_pkg::*;

	logic [TICKS_W-1:0] long_press_ticks_q;
	logic [TICKS_W-1:0] double_click_ticks_q;

	logic                   valid_s1;
	logic [STAMP_W-1:0]     now_s1;
	logic [NUM_BUTTONS-1:0] levels_s1;
	logic                   advance;

	logic [NUM_BUTTONS-1:0] press_m;
	logic [NUM_BUTTONS-1:0] long_m;
	logic [NUM_BUTTONS-1:0] dbl_m;
	logic [NUM_BUTTONS-1:0] held_m;

	logic                   out_valid_q;
	logic [NUM_BUTTONS-1:0] press_q;
	logic [NUM_BUTTONS-1:0] long_q;
	logic [NUM_BUTTONS-1:0] dbl_q;
	logic [NUM_BUTTONS-1:0] held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_ticks_q   <= LONG_PRESS_RST;
			double_click_ticks_q <= DOUBLE_CLICK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LONG_PRESS:   long_press_ticks_q   <= cfg_data;
				REG_DOUBLE_CLICK: double_click_ticks_q <= cfg_data;
			endcase
		end
	end

	assign advance       = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			now_s1    <= s_axis_tdata[STAMP_W-1:0];
			levels_s1 <= s_axis_tdata[STAMP_W +: NUM_BUTTONS];
		end
	end

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
		btn_flags_t flags;

		bgd_button u_button (
			.clk                (clk),
			.arst_n             (arst_n),
			.en                 (advance),
			.now_ticks          (now_s1),
			.pressed            (~levels_s1[b]),
			.long_press_ticks   (long_press_ticks_q),
			.double_click_ticks (double_click_ticks_q),
			.flags              (flags)
		);

		assign press_m[b] = flags.press;
		assign long_m[b]  = flags.long_press;
		assign dbl_m[b]   = flags.double_click;
		assign held_m[b]  = flags.held;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			press_q <= press_m;
			long_q  <= long_m;
			dbl_q   <= dbl_m;
			held_q  <= held_m;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TW'({held_q, dbl_q, long_q, press_q});

endmodule

// ===== src/bgd_button.sv =====
// Per-button state and gesture classification for one sampling tick.
`timescale 1ns / 1ps

module bgd_button (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic [bgd_pkg::STAMP_W-1:0] now_ticks,
	input  logic                        pressed,
	input  logic [bgd_pkg::TICKS_W-1:0] long_press_ticks,
	input  logic [bgd_pkg::TICKS_W-1:0] double_click_ticks,
	output bgd_pkg::btn_flags_t         flags
);
	import bgd_pkg::*;

	logic               held_q;
	logic [STAMP_W-1:0] press_stamp_q;
	logic [STAMP_W-1:0] release_stamp_q;
	logic [TALLY_W-1:0] click_tally_q;

	logic [STAMP_W-1:0] held_dur;
	logic [STAMP_W-1:0] since_release;
	logic               press_evt;
	logic               release_evt;
	logic               long_evt;
	logic               click_evt;
	logic               dbl_evt;
	logic               timeout;
	logic [TALLY_W-1:0] tally_inc;
	logic [TALLY_W-1:0] tally_mid;
	logic [TALLY_W-1:0] tally_next;
	logic               held_next;

	assign held_dur      = now_ticks - press_stamp_q;
	assign since_release = now_ticks - release_stamp_q;
	assign press_evt     = pressed & ~held_q;
	assign release_evt   = ~pressed & held_q;
	assign long_evt      = release_evt & (held_dur > STAMP_W'(long_press_ticks));
	assign click_evt     = release_evt & ~long_evt;
	assign tally_inc     = click_tally_q + TALLY_W'(1);
	assign dbl_evt       = click_evt & (tally_inc >= CLICKS_FOR_DOUBLE);
	assign held_next     = press_evt | (held_q & ~release_evt);

	always_comb begin
		tally_mid = click_tally_q;
		if (click_evt) begin
			tally_mid = dbl_evt ? '0 : tally_inc;
		end
	end

	// a fresh release has zero elapsed time, so it never times out
	assign timeout    = (tally_mid != '0) & ~release_evt
		& (since_release > STAMP_W'(double_click_ticks));
	assign tally_next = timeout ? '0 : tally_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q          <= 1'b0;
			press_stamp_q   <= '0;
			release_stamp_q <= '0;
			click_tally_q   <= '0;
		end else if (en) begin
			held_q        <= held_next;
			click_tally_q <= tally_next;
			if (press_evt) begin
				press_stamp_q <= now_ticks;
			end
			if (release_evt) begin
				release_stamp_q <= now_ticks;
			end
		end
	end

	assign flags.press        = press_evt;
	assign flags.long_press   = long_evt;
	assign flags.double_click = dbl_evt;
	assign flags.held         = held_next;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for button_gesture_detector_core: directed gestures and random ticks.
`timescale 1ns / 1ps

module testbench;
	import bgd_pkg::*;

	typedef struct packed {
		logic [2:0] held;
		logic [2:0] dbl;
		logic [2:0] lng;
		logic [2:0] press;
	} gesture_masks_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_LONG_PRESS;
	logic [TICKS_W-1:0] cfg_data = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [39:0]        s_axis_tdata = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [15:0]        m_axis_tdata;

	// predictor copy of thresholds and per-button state
	logic [TICKS_W-1:0] long_limit = LONG_PRESS_RST;
	logic [TICKS_W-1:0] dbl_window = DOUBLE_CLICK_RST;
	logic [2:0]         held_now = '0;
	logic [31:0]        down_stamp [3] = '{default: '0};
	logic [31:0]        up_stamp [3] = '{default: '0};
	logic [TALLY_W-1:0] clicks [3] = '{default: '0};

	gesture_masks_t expected_masks [$];
	gesture_masks_t want, seen;
	int fail_count = 0;
	bit source_stall = 1'b1;
	bit sink_stall = 1'b1;

	logic [31:0] stamp_now = '0;
	logic [2:0]  levels = 3'b111;

	button_gesture_detector_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic classify_tick(input logic [31:0] now, input logic [2:0] lv);
		gesture_masks_t g;
		logic [31:0] span;
		int b;
		g = '0;
		for (b = 0; b < 3; b++) begin
			if (!lv[b] && !held_now[b]) begin
				held_now[b] = 1'b1;
				down_stamp[b] = now;
				g.press[b] = 1'b1;
			end else if (lv[b] && held_now[b]) begin
				span = now - down_stamp[b];
				held_now[b] = 1'b0;
				up_stamp[b] = now;
				if (span > {16'b0, long_limit}) begin
					g.lng[b] = 1'b1;
				end else begin
					clicks[b] = clicks[b] + 1'b1;
					if (clicks[b] >= CLICKS_FOR_DOUBLE) begin
						g.dbl[b] = 1'b1;
						clicks[b] = '0;
					end
				end
			end
			span = now - up_stamp[b];
			if (clicks[b] != 0 && span > {16'b0, dbl_window})
				clicks[b] = '0;
			g.held[b] = held_now[b];
		end
		expected_masks.push_back(g);
	endtask

	task automatic send_tick(input logic [31:0] now, input logic [2:0] lv);
		if (source_stall && $urandom_range(99) < 35) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 35);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b0, lv, now};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		classify_tick(now, lv);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_masks.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_thresholds(input logic [15:0] lp, input logic [15:0] dc);
		cfg_we <= 1'b1;
		cfg_index <= REG_LONG_PRESS;
		cfg_data <= lp;
		@(posedge clk);
		long_limit = lp;
		cfg_index <= REG_DOUBLE_CLICK;
		cfg_data <= dc;
		@(posedge clk);
		dbl_window = dc;
		cfg_we <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [2:0] exp_v, input logic [2:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen = gesture_masks_t'(m_axis_tdata[11:0]);
			if (expected_masks.size() == 0) begin
				$error("unexpected result transaction %0h", m_axis_tdata);
				fail_count++;
			end else begin
				want = expected_masks.pop_front();
				check_field("press_mask", want.press, seen.press);
				check_field("long_press_mask", want.lng, seen.lng);
				check_field("double_click_mask", want.dbl, seen.dbl);
				check_field("held_mask", want.held, seen.held);
			end
		end
		m_axis_tready <= !sink_stall || ($urandom_range(99) >= 35);
	end

	// reset thresholds: click at exactly the limit, double click, long press, timeout
	task automatic test_default_gestures();
		send_tick(32'd0, 3'b111);
		send_tick(32'd10, 3'b110);
		send_tick(32'd1010, 3'b111);
		send_tick(32'd1020, 3'b110);
		send_tick(32'd1030, 3'b111);
		send_tick(32'd2000, 3'b110);
		send_tick(32'd3001, 3'b111);
		send_tick(32'd3001, 3'b000);
		send_tick(32'd3002, 3'b111);
		send_tick(32'd3303, 3'b111);
		drain_results();
	endtask

	task automatic test_threshold_extremes();
		set_thresholds(16'd0, 16'd0);
		send_tick(32'd5, 3'b101);
		send_tick(32'd5, 3'b111);
		send_tick(32'd5, 3'b101);
		send_tick(32'd5, 3'b111);
		send_tick(32'd6, 3'b011);
		send_tick(32'd7, 3'b111);
		drain_results();
	endtask

	// wrapped stamps, stamps in the future, long hold keeping a pending click
	task automatic test_wrap_and_pending();
		set_thresholds(16'hFFFF, 16'hFFFF);
		send_tick(32'hFFFF_FFF0, 3'b110);
		send_tick(32'h0000_0010, 3'b111);
		send_tick(32'h0001_0010, 3'b111);
		send_tick(32'd100, 3'b110);
		send_tick(32'd200, 3'b111);
		send_tick(32'd300, 3'b110);
		send_tick(32'd100000, 3'b111);
		send_tick(32'd100001, 3'b110);
		send_tick(32'd100002, 3'b111);
		send_tick(32'd50, 3'b101);
		send_tick(32'd40, 3'b111);
		drain_results();
	endtask

	task automatic run_random_ticks(input int count);
		logic [31:0] dt;
		int unsigned span;
		int k, sel, b, i;
		span = ((long_limit > dbl_window) ? long_limit : dbl_window) / 2 + 3;
		for (k = 0; k < count; k++) begin
			sel = $urandom_range(99);
			b = $urandom_range(2);
			if (sel < 8 && held_now[b]) begin
				stamp_now = down_stamp[b] + long_limit + $urandom_range(1);
				levels[b] = 1'b1;
			end else if (sel < 14 && clicks[b] != 0) begin
				stamp_now = up_stamp[b] + dbl_window + $urandom_range(1);
			end else begin
				if (sel < 30)
					dt = '0;
				else if (sel < 35)
					dt = $urandom();
				else
					dt = $urandom_range(span);
				stamp_now = stamp_now + dt;
				if ($urandom_range(99) < 8)
					levels = 3'($urandom_range(7));
				else
					for (i = 0; i < 3; i++)
						if ($urandom_range(99) < 35)
							levels[i] = ~levels[i];
			end
			send_tick(stamp_now, levels);
		end
	endtask

	task automatic test_random_traffic();
		int p;
		for (p = 0; p < 5; p++) begin
			case (p)
				0: set_thresholds(LONG_PRESS_RST, DOUBLE_CLICK_RST);
				1: set_thresholds(16'd0, 16'd0);
				2: set_thresholds(16'hFFFF, 16'hFFFF);
				3: set_thresholds(16'($urandom_range(200, 1)), 16'($urandom_range(200, 1)));
				default: set_thresholds(16'($urandom_range(16'hFFFF)),
					16'($urandom_range(16'hFFFF)));
			endcase
			source_stall = (p != 3);
			sink_stall = (p != 3);
			run_random_ticks(215);
			drain_results();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_gestures();
		test_threshold_extremes();
		test_wrap_and_pending();
		test_random_traffic();
		if (fail_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("testbench: errors");
		$finish;
	end

endmodule
